// File: rtl/life_cellular_automaton_step_macros.svh
// Assertion macros for modules that check their own behavior.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lca_pkg.sv
`default_nettype none

package lca_pkg;

	// Field widths of the item, result and configuration channels.
	localparam int FUNC_W     = 2;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 5;
	localparam int GW_W       = 7;
	localparam int GH_W       = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	// Reset values of the grid size registers.
	localparam logic [GW_W-1:0] GW_RESET = 7'd36;
	localparam logic [GH_W-1:0] GH_RESET = 6'd22;

	// Neighbor counts of the life rule.
	localparam logic [3:0] NEIGH_STAY  = 4'd2;
	localparam logic [3:0] NEIGH_BIRTH = 4'd3;

	// Operation codes of an input item.
	typedef enum logic [FUNC_W-1:0] {
		FN_WRITE   = 2'd0,
		FN_ADVANCE = 2'd1,
		FN_READ    = 2'd2,
		FN_NONE    = 2'd3
	} lca_func_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CELL,
		ST_GEN,
		ST_DRAIN,
		ST_DONE
	} lca_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic cell_rd;
		logic cell_wr;
		logic gen_start;
		logic gen_issue;
		logic gen_finish;
		logic res_load;
	} lca_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		lca_func_t func;
		logic      in_grid;
		logic      issue_last;
		logic      pipe_busy;
	} lca_sts_t;

endpackage

`default_nettype wire

// File: rtl/life_cellular_automaton_step.sv
// Game of Life on a bounded, non-wrapping grid held in a row-wide memory with one
// read and one write port. Each accepted item gives one result: a cell write or
// read goes through decode and a row read, where a write puts the row back, to its
// loaded result; an unused code or an out-of-grid coordinate goes from decode to
// the result; a generation sweeps one row read per cycle through the memory read
// port, writing each new row back in place behind a three-row window. Reset
// needs no clearing pass; per-row valid bits make the grid read as dead at once.
// Configuration is accepted every cycle and must only be written while idle.
`default_nettype none

`include "life_cellular_automaton_step_macros.svh"

module life_cellular_automaton_step #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire [lca_pkg::FUNC_W-1:0]       func,
	input  wire [lca_pkg::COL_W-1:0]        col,
	input  wire [lca_pkg::ROW_W-1:0]        row,
	input  wire                             value,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            cell_value,
	output logic                            out_of_range,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [lca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [lca_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lca_pkg::*;

	logic [GW_W-1:0] grid_width_q;
	logic [GH_W-1:0] grid_height_q;
	lca_cmd_t        cmd;
	lca_sts_t        sts;

	// Configuration registers; every write transfer is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW_RESET;
			grid_height_q <= GH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[GW_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[GH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Controller.
	lca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Grid datapath.
	lca_grid #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_grid (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.grid_width   (grid_width_q),
		.grid_height  (grid_height_q),
		.func         (func),
		.col          (col),
		.row          (row),
		.value        (value),
		.cell_value   (cell_value),
		.out_of_range (out_of_range)
	);

	// An accepted item keeps the input side stalled until its result is loaded.
	`LCA_ASSERT_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall, "input not stalled after accept")

	// A fresh result appears only as the controller returns to idle.
	`LCA_ASSERT_SAME(a_result_at_idle, $rose(out_valid), !in_stall, "result loaded while still busy")

	// A result never reports a cell value and an out-of-grid coordinate together.
	`LCA_ASSERT_SAME(a_result_fields, out_valid, !(cell_value && out_of_range), "conflicting result")

endmodule

`default_nettype wire

// File: rtl/lca_ctrl.sv
`default_nettype none

module lca_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	input  lca_pkg::lca_sts_t sts,
	output lca_pkg::lca_cmd_t cmd
);
	import lca_pkg::*;

	lca_state_t state_q;
	lca_state_t state_nxt;
	logic       out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.func) inside
					FN_WRITE, FN_READ: begin
						if (sts.in_grid) begin
							cmd.cell_rd = 1'b1;
							state_nxt   = ST_CELL;
						end else begin
							state_nxt = ST_DONE;
						end
					end
					FN_ADVANCE: begin
						cmd.gen_start = 1'b1;
						state_nxt     = ST_GEN;
					end
					default: begin
						state_nxt = ST_DONE;
					end
				endcase
			end
			ST_CELL: begin
				// The row is now read; a write puts it back with one bit changed.
				cmd.cell_wr = (sts.func == FN_WRITE);
				state_nxt   = ST_DONE;
			end
			ST_GEN: begin
				cmd.gen_issue = 1'b1;
				if (sts.issue_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.gen_finish = 1'b1;
					state_nxt      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.res_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Output register valid: set on load, cleared by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/lca_grid.sv
`default_nettype none

module lca_grid #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  lca_pkg::lca_cmd_t           cmd,
	output lca_pkg::lca_sts_t           sts,
	input  wire [lca_pkg::GW_W-1:0]     grid_width,
	input  wire [lca_pkg::GH_W-1:0]     grid_height,
	input  wire [lca_pkg::FUNC_W-1:0]   func,
	input  wire [lca_pkg::COL_W-1:0]    col,
	input  wire [lca_pkg::ROW_W-1:0]    row,
	input  wire                         value,
	output logic                        cell_value,
	output logic                        out_of_range
);
	import lca_pkg::*;

	localparam int RAW = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CIW = $clog2(MAX_COLS);

	// Grid size in use, clamped to the storage.
	logic [15:0]         gw16;
	logic [15:0]         gh16;
	logic [15:0]         nc16;
	logic [15:0]         nr16;
	logic [RCW-1:0]      nr_cnt;
	logic [MAX_COLS-1:0] col_mask;

	// Captured item.
	lca_func_t           func_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                value_q;
	logic                inside_q;
	logic [15:0]         row_ext;
	logic [15:0]         col_ext;
	logic [RAW-1:0]      row_idx;
	logic [CIW-1:0]      col_idx;

	// Row memory and per-row valid bits.
	logic [MAX_COLS-1:0] mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_vld_q;
	logic                rd_en;
	logic [RAW-1:0]      rd_addr;
	logic [MAX_COLS-1:0] rd_data_q;
	logic                rd_rowv_q;
	logic [MAX_COLS-1:0] rd_row;
	logic                wr_en;
	logic [RAW-1:0]      wr_addr;
	logic [MAX_COLS-1:0] wr_data;
	logic [MAX_COLS-1:0] cell_row;

	// Generation sweep.
	logic [RCW-1:0]      gen_k_q;
	logic                issue_last;
	logic                sh_vld_s1;
	logic                sh_zero_s1;
	logic [RCW-1:0]      sh_idx_s1;
	logic [RCW-1:0]      sh_prev;
	logic                wr_vld_s2;
	logic [RAW-1:0]      wr_idx_s2;
	logic [MAX_COLS-1:0] above_q;
	logic [MAX_COLS-1:0] mid_q;
	logic [MAX_COLS-1:0] below_q;
	logic [MAX_COLS-1:0] below_in;
	logic [MAX_COLS+1:0] ap;
	logic [MAX_COLS+1:0] mp;
	logic [MAX_COLS+1:0] bp;
	logic [MAX_COLS-1:0] next_row;

	// Result register.
	logic                cell_value_q;
	logic                oor_q;

	// Clamp the configured size and build the column mask.
	always_comb begin
		gw16   = 16'(grid_width);
		gh16   = 16'(grid_height);
		nc16   = (gw16 > 16'(MAX_COLS)) ? 16'(MAX_COLS) : gw16;
		nr16   = (gh16 > 16'(MAX_ROWS)) ? 16'(MAX_ROWS) : gh16;
		nr_cnt = nr16[RCW-1:0];
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = (16'(c) < nc16);
		end
	end

	// Capture the item and whether its coordinate lies in the grid.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= lca_func_t'(func);
			col_q    <= col;
			row_q    <= row;
			value_q  <= value;
			inside_q <= (16'(col) < nc16) && (16'(row) < nr16);
		end
	end

	assign row_ext = 16'(row_q);
	assign col_ext = 16'(col_q);
	assign row_idx = row_ext[RAW-1:0];
	assign col_idx = col_ext[CIW-1:0];

	// Sweep counter: one row read is issued per cycle, the last step feeds a dead row.
	always_ff @(posedge clk) begin
		if (cmd.gen_start) begin
			gen_k_q <= '0;
		end else if (cmd.gen_issue) begin
			gen_k_q <= gen_k_q + RCW'(1);
		end
	end

	assign issue_last = (gen_k_q == nr_cnt);

	// Memory read port.
	assign rd_en   = cmd.cell_rd || (cmd.gen_issue && !issue_last);
	assign rd_addr = cmd.gen_issue ? gen_k_q[RAW-1:0] : row_idx;

	// A row that was never written since reset or a generation reads as dead.
	assign rd_row = rd_rowv_q ? rd_data_q : '0;

	// Cell write: the read row with one bit replaced.
	always_comb begin
		cell_row          = rd_row;
		cell_row[col_idx] = value_q;
	end

	// Memory write port, shared by cell writes and the sweep.
	assign wr_en   = wr_vld_s2 || cmd.cell_wr;
	assign wr_addr = wr_vld_s2 ? wr_idx_s2 : row_idx;
	assign wr_data = wr_vld_s2 ? next_row : cell_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_rowv_q <= row_vld_q[rd_addr];
		end
	end

	// Row valid bits: set by a write, cleared beyond the rows in use when a generation ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.gen_finish) begin
				for (int r = 0; r < MAX_ROWS; r++) begin
					if (16'(r) >= nr16) begin
						row_vld_q[r] <= 1'b0;
					end
				end
			end
		end
	end

	// Sweep pipeline control: read, shift into the window, write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_vld_s1 <= 1'b0;
			wr_vld_s2 <= 1'b0;
		end else begin
			sh_vld_s1 <= cmd.gen_issue;
			wr_vld_s2 <= sh_vld_s1 && (sh_idx_s1 != '0);
		end
	end

	assign sh_prev = sh_idx_s1 - RCW'(1);

	always_ff @(posedge clk) begin
		sh_zero_s1 <= issue_last;
		sh_idx_s1  <= gen_k_q;
		wr_idx_s2  <= sh_prev[RAW-1:0];
	end

	// Three-row window of the old generation; columns beyond the grid enter as dead.
	assign below_in = sh_zero_s1 ? '0 : (rd_row & col_mask);

	always_ff @(posedge clk) begin
		if (cmd.gen_start) begin
			above_q <= '0;
			mid_q   <= '0;
			below_q <= '0;
		end else if (sh_vld_s1) begin
			above_q <= mid_q;
			mid_q   <= below_q;
			below_q <= below_in;
		end
	end

	// Life rule for every column of the middle row.
	always_comb begin
		logic [3:0] cnt;
		ap = {1'b0, above_q, 1'b0};
		mp = {1'b0, mid_q, 1'b0};
		bp = {1'b0, below_q, 1'b0};
		for (int c = 0; c < MAX_COLS; c++) begin
			cnt = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2]) + 4'(mp[c]) + 4'(mp[c+2])
				+ 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
			if (mid_q[c]) begin
				next_row[c] = col_mask[c] && ((cnt == NEIGH_STAY) || (cnt == NEIGH_BIRTH));
			end else begin
				next_row[c] = col_mask[c] && (cnt == NEIGH_BIRTH);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			cell_value_q <= (func_q == FN_READ) && inside_q && rd_row[col_idx];
			oor_q        <= ((func_q == FN_WRITE) || (func_q == FN_READ)) && !inside_q;
		end
	end

	assign cell_value   = cell_value_q;
	assign out_of_range = oor_q;

	// Status to the controller.
	always_comb begin
		sts.func       = func_q;
		sts.in_grid    = inside_q;
		sts.issue_last = issue_last;
		sts.pipe_busy  = sh_vld_s1 || wr_vld_s2;
	end

endmodule

`default_nettype wire
